>>> rtl/core/mkt_pkg.sv
package mkt_pkg;

	// per-slot key states
	localparam logic [1:0] ST_IDLE     = 2'd0;
	localparam logic [1:0] ST_PRESSED  = 2'd1;
	localparam logic [1:0] ST_HOLD     = 2'd2;
	localparam logic [1:0] ST_RELEASED = 2'd3;

	// configuration register map
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 16;
	localparam logic [CFG_IDX_W-1:0] IDX_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] IDX_HOLD     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] IDX_ROWS     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] IDX_COLS     = 2'd3;

	// register reset values
	localparam logic [15:0] DEBOUNCE_RST = 16'd10;
	localparam logic [15:0] HOLD_RST     = 16'd1000;
	localparam logic [2:0]  ROWS_RST     = 3'd4;
	localparam logic [2:0]  COLS_RST     = 3'd4;

	// controller to datapath commands
	typedef struct packed {
		logic tick;   // take the tick word, advance the ms counter
		logic start;  // open a scan
		logic free;   // release idle slots
		logic step;   // process one key of the walk
		logic flush;  // send the held event as last of the scan
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic due;         // debounce interval has passed
		logic walk_empty;  // no rows or no columns in use
		logic walk_last;   // current key is the last of the walk
		logic room;        // output register can take a word this cycle
	} sts_t;

endpackage

>>> rtl/core/mkt_ctrl.sv
module mkt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output mkt_pkg::cmd_t cmd,
	input  mkt_pkg::sts_t st
);
	import mkt_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_FREE  = 3'd2;
	localparam logic [2:0] S_WALK  = 3'd3;
	localparam logic [2:0] S_FLUSH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// only an idle controller takes a tick
	assign in_stall = (state_q != S_IDLE);

	// next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.tick = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (st.due) begin
					cmd.start = 1'b1;
					state_d   = S_FREE;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_FREE: begin
				cmd.free = 1'b1;
				state_d  = st.walk_empty ? S_FLUSH : S_WALK;
			end
			S_WALK: begin
				if (st.room) begin
					cmd.step = 1'b1;
					if (st.walk_last) begin
						state_d = S_FLUSH;
					end
				end
			end
			S_FLUSH: begin
				if (st.room) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/mkt_datapath.sv
module mkt_datapath #(
	parameter int ROWS  = 4,
	parameter int COLS  = 4,
	parameter int SLOTS = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [15:0]                       key_matrix,
	input  logic                              cfg_we,
	input  logic [mkt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mkt_pkg::CFG_DAT_W-1:0]     cfg_data,
	input  mkt_pkg::cmd_t                     cmd,
	output mkt_pkg::sts_t                     st,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic [3:0]                        key_code,
	output logic [3:0]                        slot_index,
	output logic [1:0]                        new_state,
	output logic                              last_event
);
	import mkt_pkg::*;

	localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW  = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int REW = $clog2(ROWS + 1);
	localparam int CEW = $clog2(COLS + 1);
	localparam int KW  = (ROWS * COLS > 1) ? $clog2(ROWS * COLS) : 1;
	localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NW  = $clog2(SLOTS + 1);

	// configuration
	logic [15:0] debounce_q;
	logic [15:0] hold_q;
	logic [2:0]  rows_q;
	logic [2:0]  cols_q;

	// timers and tick word
	logic [15:0] matrix_q;
	logic [31:0] now_q;
	logic [31:0] scan_start_q;
	logic [31:0] hold_start_q;

	// active-key list
	logic [SLOTS-1:0] valid_q;
	logic [KW-1:0]    key_q   [SLOTS];
	logic [1:0]       sstate_q[SLOTS];

	// walk position and event count
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [NW-1:0] cnt_q;

	// held event, sent once the next one is known
	logic          pend_valid_q;
	logic [KW-1:0] pend_key_q;
	logic [SW-1:0] pend_slot_q;
	logic [1:0]    pend_state_q;

	// output register
	logic       out_valid_q;
	logic [3:0] out_key_q;
	logic [3:0] out_slot_q;
	logic [1:0] out_state_q;
	logic       out_last_q;

	logic [REW-1:0] rows_eff;
	logic [CEW-1:0] cols_eff;
	logic           col_last;
	logic [7:0]     bit_idx;
	logic           pressed;
	logic [KW-1:0]  code;
	logic           found;
	logic [SW-1:0]  found_idx;
	logic           has_free;
	logic [SW-1:0]  free_idx;
	logic [SW-1:0]  tgt;
	logic [1:0]     cur;
	logic [1:0]     nxt;
	logic           act;
	logic           held_over;
	logic           rec;
	logic           push;
	logic [7:0]     pend_key_ext;

	// clamp the scanned area to the array size
	assign rows_eff = (32'(rows_q) < ROWS) ? REW'(rows_q) : REW'(ROWS);
	assign cols_eff = (32'(cols_q) < COLS) ? CEW'(cols_q) : CEW'(COLS);
	assign col_last = (32'(col_q) == 32'(cols_eff) - 32'd1);

	// current key: matrix bit and code
	assign bit_idx = 8'(32'(row_q) * COLS + 32'(col_q));
	assign pressed = (bit_idx < 8'd16) && matrix_q[bit_idx[3:0]];
	assign code    = KW'(32'(row_q) * 32'(cols_eff) + 32'(col_q));

	// lowest slot holding the code, lowest free slot
	always_comb begin
		found     = 1'b0;
		found_idx = '0;
		has_free  = 1'b0;
		free_idx  = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (valid_q[i] && key_q[i] == code) begin
				found     = 1'b1;
				found_idx = SW'(i);
			end
			if (!valid_q[i]) begin
				has_free = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	assign held_over = (now_q - hold_start_q) > 32'(hold_q);
	assign tgt       = found ? found_idx : free_idx;
	assign cur       = found ? sstate_q[found_idx] : ST_IDLE;
	assign act       = found || (pressed && has_free);

	// key state step; hold timeout wins over release
	always_comb begin
		nxt = cur;
		case (cur)
			ST_IDLE: begin
				if (pressed) begin
					nxt = ST_PRESSED;
				end
			end
			ST_PRESSED: begin
				if (held_over) begin
					nxt = ST_HOLD;
				end else if (!pressed) begin
					nxt = ST_RELEASED;
				end
			end
			ST_HOLD: begin
				if (!pressed) begin
					nxt = ST_RELEASED;
				end
			end
			default: begin
				nxt = ST_IDLE;
			end
		endcase
	end

	// an event is kept while the scan has had fewer than SLOTS of them
	assign rec  = act && (nxt != cur) && (32'(cnt_q) < SLOTS);
	assign push = pend_valid_q && ((cmd.step && rec) || cmd.flush);

	assign st.due        = (now_q - scan_start_q) > 32'(debounce_q);
	assign st.walk_empty = (rows_eff == '0) || (cols_eff == '0);
	assign st.walk_last  = (32'(row_q) == 32'(rows_eff) - 32'd1) && col_last;
	assign st.room       = !out_valid_q || !out_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			hold_q     <= HOLD_RST;
			rows_q     <= ROWS_RST;
			cols_q     <= COLS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				IDX_DEBOUNCE: debounce_q <= (cfg_data == '0) ? 16'd1 : cfg_data;
				IDX_HOLD:     hold_q     <= cfg_data;
				IDX_ROWS:     rows_q     <= cfg_data[2:0];
				IDX_COLS:     cols_q     <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// tick capture and timers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q        <= '0;
			scan_start_q <= '0;
			hold_start_q <= '0;
		end else begin
			if (cmd.tick) begin
				now_q <= now_q + 32'd1;
			end
			if (cmd.start) begin
				scan_start_q <= now_q;
			end
			if (cmd.step && act && cur == ST_IDLE && pressed) begin
				hold_start_q <= now_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			matrix_q <= key_matrix;
		end
	end

	// slot list: free pass and per-key update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				key_q[i]    <= '0;
				sstate_q[i] <= ST_IDLE;
			end
		end else if (cmd.free) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (valid_q[i] && sstate_q[i] == ST_IDLE) begin
					valid_q[i] <= 1'b0;
				end
			end
		end else if (cmd.step && act) begin
			valid_q[tgt]  <= 1'b1;
			key_q[tgt]    <= code;
			sstate_q[tgt] <= nxt;
		end
	end

	// walk position and event count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			cnt_q <= '0;
		end else if (cmd.start) begin
			row_q <= '0;
			col_q <= '0;
			cnt_q <= '0;
		end else if (cmd.step) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
			if (rec) begin
				cnt_q <= cnt_q + NW'(1);
			end
		end
	end

	// held event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.start || cmd.flush) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.step && rec) begin
			pend_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && rec) begin
			pend_key_q   <= code;
			pend_slot_q  <= tgt;
			pend_state_q <= nxt;
		end
	end

	// output register
	assign pend_key_ext = 8'(pend_key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_key_q   <= pend_key_ext[3:0];
			out_slot_q  <= 4'(pend_slot_q);
			out_state_q <= pend_state_q;
			out_last_q  <= cmd.flush;
		end
	end

	assign out_valid  = out_valid_q;
	assign key_code   = out_key_q;
	assign slot_index = out_slot_q;
	assign new_state  = out_state_q;
	assign last_event = out_last_q;

endmodule

>>> rtl/core/matrix_keypad_multikey_tracker_top.sv
// Multi-key matrix keypad tracker.
// Input channel (in_valid / in_stall): one word per millisecond tick carrying
// the active-high key matrix in key_matrix. Output channel (out_valid /
// out_stall): one word per key state change (at most SLOTS per scan), with
// key_code, slot_index, new_state, last_event set on a scan's final word.
// Configuration: cfg_we with cfg_index 0 debounce_ms, 1 hold_ms,
// 2 rows_in_use, 3 cols_in_use; write only while the block is idle.
// Timing: a tick that runs no scan is only taken and checked. A tick that
// runs a scan goes through take, check, free pass, a walk over the keys in
// use and flush, and waits while the output side stalls. An event word is
// held until the next event of its scan or the flush, then registered. Every
// key of the walk goes through one shared slot search and state update, one
// key per cycle while the output has room; a new tick is taken only when the
// previous one is finished. The output word sits in a register: a stalled
// receiver holds it there and freezes the walk until it is taken.
// Reset clears the slot list and the ms timers and restores the register
// defaults (debounce 10, hold 1000, 4 rows, 4 columns).
module matrix_keypad_multikey_tracker_top #(
	parameter int ROWS  = 4,
	parameter int COLS  = 4,
	parameter int SLOTS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [15:0]                   key_matrix,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [3:0]                    key_code,
	output logic [3:0]                    slot_index,
	output logic [1:0]                    new_state,
	output logic                          last_event,
	input  logic                          cfg_we,
	input  logic [mkt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mkt_pkg::CFG_DAT_W-1:0] cfg_data
);
	import mkt_pkg::*;

	cmd_t cmd;
	sts_t st;

	mkt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.st       (st)
	);

	mkt_datapath #(
		.ROWS  (ROWS),
		.COLS  (COLS),
		.SLOTS (SLOTS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_matrix (key_matrix),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.st         (st),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.key_code   (key_code),
		.slot_index (slot_index),
		.new_state  (new_state),
		.last_event (last_event)
	);

	// walk steps and flush only fire when the output register has room
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step || cmd.flush) |-> st.room)
		else $error("walk advanced without output room");

	// at most one command per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.tick, cmd.start, cmd.free, cmd.step, cmd.flush}))
		else $error("more than one datapath command");

	// end of a scan frees the input side
	a_flush_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> !in_stall)
		else $error("input still stalled after scan end");

	// a tick is only taken when not busy
	a_tick_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick |-> (in_valid && !in_stall))
		else $error("tick taken while busy");

endmodule

>>> tb/sv/matrix_keypad_multikey_tracker_top_test.sv
module matrix_keypad_multikey_tracker_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	import mkt_pkg::*;

	localparam int KEY_ROWS      = 4;
	localparam int KEY_COLS      = 4;
	localparam int KEY_SLOTS     = 10;
	localparam int SETTLE_CYCLES = 40;      // longest scan with no event, with margin
	localparam int TICK_TARGET   = 240;
	localparam int CALM_FROM     = 190;     // no idling on either side past this tick
	localparam int LIMIT_CYCLES  = 500000;

	// one event word as the block sends it
	typedef struct packed {
		logic [3:0] code;
		logic [3:0] slot;
		logic [1:0] state;
		logic       last;
	} key_event_t;

	// Tracks the slot list and timers, predicts the event words of every scan
	// and checks the words that come out against them in order.
	class key_event_board;
		logic [31:0] debounce_ms;
		logic [31:0] hold_ms;
		logic [2:0]  rows_used;
		logic [2:0]  cols_used;
		bit          slot_busy[KEY_SLOTS];
		logic [3:0]  slot_key[KEY_SLOTS];
		logic [1:0]  slot_state[KEY_SLOTS];
		logic [31:0] now_ms;
		logic [31:0] scan_start_ms;
		logic [31:0] hold_start_ms;
		key_event_t  scan_events[$];
		key_event_t  due_events[$];
		int          mismatches;
		int          ticks;
		int          scans;
		int          events_checked;

		function new();
			debounce_ms = DEBOUNCE_RST;
			hold_ms     = HOLD_RST;
			rows_used   = ROWS_RST;
			cols_used   = COLS_RST;
			foreach (slot_busy[i]) begin
				slot_busy[i]  = 1'b0;
				slot_key[i]   = '0;
				slot_state[i] = ST_IDLE;
			end
			now_ms         = '0;
			scan_start_ms  = '0;
			hold_start_ms  = '0;
			mismatches     = 0;
			ticks          = 0;
			scans          = 0;
			events_checked = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				IDX_DEBOUNCE: debounce_ms = (data == '0) ? 32'd1 : 32'(data);
				IDX_HOLD:     hold_ms     = 32'(data);
				IDX_ROWS:     rows_used   = data[2:0];
				IDX_COLS:     cols_used   = data[2:0];
				default:      ;
			endcase
		endfunction

		// one state machine step of a slot; a change yields an event word
		function void step_slot(int s, bit pressed);
			logic [1:0] nxt;
			nxt = slot_state[s];
			case (slot_state[s])
				ST_IDLE: begin
					if (pressed) begin
						nxt           = ST_PRESSED;
						hold_start_ms = now_ms;
					end
				end
				ST_PRESSED: begin
					// hold timeout wins over release
					if (now_ms - hold_start_ms > hold_ms)
						nxt = ST_HOLD;
					else if (!pressed)
						nxt = ST_RELEASED;
				end
				ST_HOLD: begin
					if (!pressed)
						nxt = ST_RELEASED;
				end
				default: nxt = ST_IDLE;
			endcase
			if (nxt != slot_state[s]) begin
				slot_state[s] = nxt;
				if (scan_events.size() < KEY_SLOTS)
					scan_events.push_back('{code: slot_key[s], slot: 4'(s),
						state: nxt, last: 1'b0});
			end
		endfunction

		// accepted tick word: advance time, run a scan when debounce has passed
		function void take_tick(logic [15:0] matrix);
			int  rows;
			int  cols;
			int  bitpos;
			int  found;
			bit  pressed;
			logic [3:0] code;
			ticks++;
			now_ms++;
			if (now_ms - scan_start_ms <= debounce_ms)
				return;
			scan_start_ms = now_ms;
			scans++;
			scan_events.delete();

			// slots that went idle last scan are released now
			foreach (slot_busy[i])
				if (slot_busy[i] && slot_state[i] == ST_IDLE)
					slot_busy[i] = 1'b0;

			rows = (rows_used < KEY_ROWS) ? int'(rows_used) : KEY_ROWS;
			cols = (cols_used < KEY_COLS) ? int'(cols_used) : KEY_COLS;

			// row-major walk over the keys in use
			for (int r = 0; r < rows; r++) begin
				for (int c = 0; c < cols; c++) begin
					bitpos  = r * KEY_COLS + c;
					pressed = (bitpos < 16) ? matrix[bitpos] : 1'b0;
					code    = 4'(r * cols + c);
					found   = -1;
					for (int i = 0; i < KEY_SLOTS; i++) begin
						if (slot_busy[i] && slot_key[i] == code) begin
							found = i;
							break;
						end
					end
					if (found >= 0) begin
						step_slot(found, pressed);
					end else if (pressed) begin
						// lowest free slot; a full list ignores the key
						for (int i = 0; i < KEY_SLOTS; i++) begin
							if (!slot_busy[i]) begin
								slot_busy[i]  = 1'b1;
								slot_key[i]   = code;
								slot_state[i] = ST_IDLE;
								step_slot(i, 1'b1);
								break;
							end
						end
					end
				end
			end

			if (scan_events.size() > 0)
				scan_events[scan_events.size() - 1].last = 1'b1;
			foreach (scan_events[i])
				due_events.push_back(scan_events[i]);
		endfunction

		task flag_mismatch(string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			mismatches++;
		endtask

		// accepted event word against the oldest expected one
		task check_event(key_event_t got);
			key_event_t want;
			if (due_events.size() == 0) begin
				flag_mismatch($sformatf("unexpected word code %0d slot %0d state %0d last %0d",
					got.code, got.slot, got.state, got.last));
				return;
			end
			want = due_events.pop_front();
			events_checked++;
			if (got.code !== want.code)
				flag_mismatch($sformatf("word %0d key_code %0d, expected %0d",
					events_checked, got.code, want.code));
			if (got.slot !== want.slot)
				flag_mismatch($sformatf("word %0d slot_index %0d, expected %0d",
					events_checked, got.slot, want.slot));
			if (got.state !== want.state)
				flag_mismatch($sformatf("word %0d new_state %0d, expected %0d",
					events_checked, got.state, want.state));
			if (got.last !== want.last)
				flag_mismatch($sformatf("word %0d last_event %0d, expected %0d",
					events_checked, got.last, want.last));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [15:0]          key_matrix;
	logic                 out_valid;
	logic                 out_stall;
	logic [3:0]           key_code;
	logic [3:0]           slot_index;
	logic [1:0]           new_state;
	logic                 last_event;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	key_event_board board = new();
	bit             calm;
	int             stall_left;
	int             cycles;
	int             settings_done;

	matrix_keypad_multikey_tracker_top #(
		.ROWS  (KEY_ROWS),
		.COLS  (KEY_COLS),
		.SLOTS (KEY_SLOTS)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.key_matrix (key_matrix),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.key_code   (key_code),
		.slot_index (slot_index),
		.new_state  (new_state),
		.last_event (last_event),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d words outstanding",
				cycles, board.due_events.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// output side: take words, stall in random bursts
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_event('{code: key_code, slot: slot_index,
				state: new_state, last: last_event});
		if (calm) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall  <= 1'b1;
			stall_left = $urandom_range(1, 11) - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// one register write; the caller lowers the write enable
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		board.set_register(idx, data);
	endtask

	// block must be idle here
	task automatic program_regs(input logic [15:0] debounce, hold, rows, cols);
		write_reg(IDX_DEBOUNCE, debounce);
		write_reg(IDX_HOLD, hold);
		write_reg(IDX_ROWS, rows);
		write_reg(IDX_COLS, cols);
		cfg_we <= 1'b0;
		settings_done++;
	endtask

	// one tick word, with an optional idle burst ahead of it
	task automatic send_tick(input logic [15:0] m);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		key_matrix <= m;
		do @(posedge clk); while (in_stall);
		board.take_tick(m);
	endtask

	// wait for every expected word, then let a silent scan finish
	task automatic drain();
		in_valid <= 1'b0;
		while (board.due_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// keys mostly stay put between ticks so press, hold and release sequences form
	function automatic logic [15:0] next_matrix(logic [15:0] held);
		logic [15:0] m;
		case ($urandom_range(0, 19))
			0:       m = 16'($urandom);
			1:       m = 16'hFFFF;
			2, 3, 4: m = held ^ (16'h1 << $urandom_range(0, 15));
			5:       m = 16'h0000;
			default: m = held;
		endcase
		return m;
	endfunction

	function automatic logic [15:0] dim_value();
		logic [2:0] v;
		v = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 7)) : 3'd4;
		return {13'($urandom), v};
	endfunction

	initial begin
		logic [15:0] matrix;
		logic [15:0] debounce;
		logic [15:0] hold;
		int          n;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		key_matrix    = '0;
		out_stall     = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = IDX_DEBOUNCE;
		cfg_data      = '0;
		calm          = 1'b0;
		stall_left    = 0;
		cycles        = 0;
		settings_done = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero debounce clamps to one; short hold
		program_regs(16'h0000, 16'd1, 16'd4, 16'd4);
		// all keys closed: ten take slots, the rest find the list full
		send_tick(16'hFFFF);
		send_tick(16'hFFFF);
		// all open, but past hold time: hold comes first
		send_tick(16'h0000);
		send_tick(16'h0000);
		send_tick(16'h0000);
		send_tick(16'h0000);
		// keys go idle while the others press against slots not yet freed
		send_tick(16'hFC00);
		send_tick(16'hFC00);
		send_tick(16'h8001);
		send_tick(16'h8001);
		send_tick(16'h0001);
		send_tick(16'h0001);
		drain();

		// rows too large, zero columns: scan walks no keys
		program_regs(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFF8);
		send_tick(16'hFFFF);
		send_tick(16'hFFFF);
		drain();

		// longest debounce: no scan at all
		program_regs(16'hFFFF, 16'h0000, 16'd2, 16'd3);
		send_tick(16'h5A5A);
		send_tick(16'hA5A5);
		send_tick(16'hFFFF);
		drain();

		// single key in use, zero hold
		program_regs(16'd2, 16'h0000, 16'd1, 16'd1);
		send_tick(16'h0000);
		send_tick(16'h0000);
		send_tick(16'h0000);
		send_tick(16'h0001);
		send_tick(16'h0001);
		send_tick(16'h0001);
		drain();

		// random phases, each under its own register setting
		matrix = 16'h0000;
		while (board.ticks < TICK_TARGET) begin
			calm = (board.ticks >= CALM_FROM);
			case ($urandom_range(0, 7))
				0:       debounce = 16'd0;
				1:       debounce = 16'($urandom_range(4, 12));
				default: debounce = 16'($urandom_range(1, 3));
			endcase
			case ($urandom_range(0, 5))
				0:       hold = 16'd0;
				1:       hold = 16'hFFFF;
				default: hold = 16'($urandom_range(1, 12));
			endcase
			program_regs(debounce, hold, dim_value(), dim_value());
			n = $urandom_range(24, 40);
			repeat (n) begin
				matrix = next_matrix(matrix);
				send_tick(matrix);
			end
			drain();
		end

		$display("Covered %0d ticks and %0d scans under %0d register settings,",
			board.ticks, board.scans, settings_done);
		$display("checked %0d key event words, %0d mismatches",
			board.events_checked, board.mismatches);
		if (board.mismatches == 0 && board.due_events.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> files.f
rtl/core/mkt_pkg.sv
rtl/core/mkt_ctrl.sv
rtl/core/mkt_datapath.sv
rtl/core/matrix_keypad_multikey_tracker_top.sv
tb/sv/matrix_keypad_multikey_tracker_top_test.sv
